>>> rtl/core/gamepad_input_conditioner_top_assert.svh
// assertion macros shared by the gamepad input conditioner modules
`ifndef GAMEPAD_INPUT_CONDITIONER_TOP_ASSERT_SVH
`define GAMEPAD_INPUT_CONDITIONER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define GIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define GIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/gic_pkg.sv
// types and constants of the gamepad input conditioner
package gic_pkg;

  localparam int unsigned AxisW      = 16;
  localparam int unsigned ButtonW    = 16;
  localparam int unsigned LevelW     = 16;
  localparam int unsigned TimeW      = 16;
  localparam int unsigned TickW      = 10;
  localparam int unsigned AlphaW     = 17;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned NumAxes    = 4;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 17;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  localparam logic [CmdW-1:0] CmdPoll     = 2'd0;
  localparam logic [CmdW-1:0] CmdSetLeft  = 2'd1;
  localparam logic [CmdW-1:0] CmdSetRight = 2'd2;

  localparam logic [CfgIdxW-1:0] RegAlpha  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTick   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWindow = 2'd2;

  localparam logic [AlphaW-1:0] AlphaOne    = 17'd65536;
  localparam logic [AlphaW-1:0] AlphaReset  = 17'd6554;
  localparam logic [TickW-1:0]  TickReset   = 10'd16;
  localparam logic [TimeW-1:0]  WindowReset = 16'd1000;

  localparam int unsigned AxisLeftX  = 0;
  localparam int unsigned AxisLeftY  = 1;
  localparam int unsigned AxisRightX = 2;
  localparam int unsigned AxisRightY = 3;

  typedef enum logic [2:0] {
    OP_POLL,
    OP_LINK_DOWN,
    OP_SET_LEFT,
    OP_SET_RIGHT,
    OP_NOP
  } gic_op_e;

  typedef enum logic [1:0] {
    QUAD_UR,
    QUAD_DR,
    QUAD_DL,
    QUAD_UL
  } gic_quad_e;

  typedef struct packed {
    gic_op_e                          op;
    logic [ButtonW-1:0]               buttons;
    logic [NumAxes-1:0][AxisW-1:0]    axes;
    logic [LevelW-1:0]                amount;
    logic [TimeW-1:0]                 duration;
  } gic_item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } gic_queue_status_t;

endpackage

>>> rtl/core/gic_front.sv
// front end: accepts input words, decodes the command and masks the buttons
module gic_front import gic_pkg::*; #(
  parameter int unsigned ButtonBits = 16
) (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CmdW-1:0]      cmd_i,
  input  logic                 connected_i,
  input  logic [ButtonW-1:0]   buttons_i,
  input  logic [AxisW-1:0]     left_stick_x_i,
  input  logic [AxisW-1:0]     left_stick_y_i,
  input  logic [AxisW-1:0]     right_stick_x_i,
  input  logic [AxisW-1:0]     right_stick_y_i,
  input  logic [LevelW-1:0]    rumble_amount_i,
  input  logic [TimeW-1:0]     rumble_time_i,
  input  gic_queue_status_t    queue_status_i,
  output logic                 push_o,
  output gic_item_t            item_o
);

  localparam int unsigned KeptBits = (ButtonBits < ButtonW) ? ButtonBits : ButtonW;

  logic [KeptBits-1:0] btn_kept;
  gic_op_e             op;

  assign btn_kept = buttons_i[KeptBits-1:0];

  always_comb begin
    unique case (cmd_i)
      CmdPoll:     op = connected_i ? OP_POLL : OP_LINK_DOWN;
      CmdSetLeft:  op = OP_SET_LEFT;
      CmdSetRight: op = OP_SET_RIGHT;
      default:     op = OP_NOP;
    endcase
  end

  always_comb begin
    item_o.op                  = op;
    item_o.buttons             = ButtonW'(btn_kept);
    item_o.axes[AxisLeftX]     = left_stick_x_i;
    item_o.axes[AxisLeftY]     = left_stick_y_i;
    item_o.axes[AxisRightX]    = right_stick_x_i;
    item_o.axes[AxisRightY]    = right_stick_y_i;
    item_o.amount              = rumble_amount_i;
    item_o.duration            = rumble_time_i;
  end

  assign in_ready_o = !queue_status_i.full;
  assign push_o     = in_valid_i && in_ready_o;

endmodule

>>> rtl/core/gic_queue.sv
// two-entry queue between the front and back ends
`include "gamepad_input_conditioner_top_assert.svh"

module gic_queue import gic_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gic_item_t         item_i,
  input  logic              pop_i,
  output gic_item_t         item_o,
  output gic_queue_status_t status_o
);

  gic_item_t            slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o         = slot_q[rd_ptr_q];
  assign status_o.valid = (cnt_q != '0);
  assign status_o.full  = (cnt_q == QueueCntW'(QueueDepth));

  `GIC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= QueueCntW'(QueueDepth), "queue count overflow")
  `GIC_ASSERT_NOW(a_no_push_full, push_i, !status_o.full, "push into full queue")
  `GIC_ASSERT_NEXT(a_pop_drains, pop_i && !push_i, (cnt_q + 1'b1) == $past(cnt_q), "pop lost")

endmodule

>>> rtl/core/gic_back.sv
// back end: button edges, axis filters, rotation gesture, rumble timers, config
`include "gamepad_input_conditioner_top_assert.svh"

module gic_back import gic_pkg::*; #(
  parameter int unsigned ButtonBits = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  gic_item_t            item_i,
  output logic                 pop_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 link_up_o,
  output logic [ButtonW-1:0]   buttons_pressed_o,
  output logic [ButtonW-1:0]   buttons_released_o,
  output logic [AxisW-1:0]     left_x_smooth_o,
  output logic [AxisW-1:0]     left_y_smooth_o,
  output logic [AxisW-1:0]     right_x_smooth_o,
  output logic [AxisW-1:0]     right_y_smooth_o,
  output logic                 rotation_done_o,
  output logic [LevelW-1:0]    left_rumble_o,
  output logic [LevelW-1:0]    right_rumble_o
);

  localparam int unsigned KeptBits = (ButtonBits < ButtonW) ? ButtonBits : ButtonW;
  localparam int unsigned ProdW    = AxisW + AlphaW + 2;
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(32'd1 << (FracBits - 1));

  logic [AlphaW-1:0] alpha_q;
  logic [TickW-1:0]  tick_q;
  logic [TimeW-1:0]  window_q;

  logic                out_valid_q, out_valid_d;
  logic                link_q, link_d;
  logic [KeptBits-1:0] prev_q, prev_d;
  logic [KeptBits-1:0] pressed_q, pressed_d;
  logic [KeptBits-1:0] released_q, released_d;
  logic [AxisW-1:0]    axis_q [NumAxes];
  logic [AxisW-1:0]    axis_d [NumAxes];
  gic_quad_e           quad_q, quad_d;
  logic [TimeW-1:0]    gtimer_q, gtimer_d;
  logic [LevelW-1:0]   level_q [2];
  logic [LevelW-1:0]   level_d [2];
  logic [TimeW-1:0]    rtimer_q [2];
  logic [TimeW-1:0]    rtimer_d [2];

  logic [AlphaW-1:0]        alpha_eff;
  logic signed [AlphaW:0]   alpha_s;
  logic signed [AxisW:0]    diff [NumAxes];
  logic signed [ProdW-1:0]  prod [NumAxes];
  logic signed [ProdW-1:0]  shifted [NumAxes];
  logic [AxisW-1:0]         filt [NumAxes];
  logic [KeptBits-1:0]      btn;
  logic signed [AxisW-1:0]  lx, ly;
  logic                     up_right;
  logic [TimeW-1:0]         gtimer_win;

  function automatic logic [TimeW-1:0] sat_sub(logic [TimeW-1:0] t, logic [TickW-1:0] d);
    logic [TimeW-1:0] dx;
    dx = TimeW'(d);
    return (t > dx) ? (t - dx) : '0;
  endfunction

  assign pop_o = item_valid_i && (!out_valid_q || out_ready_i);

  // axis filters: s + round(a * (x - s) / 2^16)
  assign alpha_eff = (alpha_q > AlphaOne) ? AlphaOne : alpha_q;
  assign alpha_s   = $signed({1'b0, alpha_eff});

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      diff[i]    = $signed({item_i.axes[i][AxisW-1], item_i.axes[i]})
                 - $signed({axis_q[i][AxisW-1], axis_q[i]});
      prod[i]    = alpha_s * diff[i];
      shifted[i] = (prod[i] + RoundHalf) >>> FracBits;
      filt[i]    = axis_q[i] + shifted[i][AxisW-1:0];
    end
  end

  assign btn        = item_i.buttons[KeptBits-1:0];
  assign lx         = $signed(item_i.axes[AxisLeftX]);
  assign ly         = $signed(item_i.axes[AxisLeftY]);
  assign up_right   = (lx > 16'sd0) && (ly > 16'sd0);
  assign gtimer_win = up_right ? window_q : gtimer_q;

  always_comb begin
    link_d     = link_q;
    prev_d     = prev_q;
    pressed_d  = pressed_q;
    released_d = released_q;
    axis_d     = axis_q;
    quad_d     = quad_q;
    gtimer_d   = gtimer_q;
    level_d    = level_q;
    rtimer_d   = rtimer_q;
    if (pop_o) begin
      unique case (item_i.op)
        OP_POLL: begin
          link_d     = 1'b1;
          pressed_d  = ~prev_q & btn;
          released_d = prev_q & ~btn;
          prev_d     = btn;
          axis_d     = filt;
          quad_d     = up_right ? QUAD_UR : quad_q;
          gtimer_d   = gtimer_win;
          if (gtimer_win != '0) begin
            gtimer_d = sat_sub(gtimer_win, tick_q);
            if (quad_d == QUAD_UL) begin
              quad_d = QUAD_UR;
            end
            if ((lx > 16'sd0) && (ly <= 16'sd0) && (quad_d == QUAD_UR)) begin
              quad_d = QUAD_DR;
            end
            if ((lx <= 16'sd0) && (ly < 16'sd0) && (quad_d == QUAD_DR)) begin
              quad_d = QUAD_DL;
            end
            if ((lx < 16'sd0) && (ly >= 16'sd0) && (quad_d == QUAD_DL)) begin
              quad_d = QUAD_UL;
            end
          end else begin
            quad_d = QUAD_UR;
          end
          for (int k = 0; k < 2; k++) begin
            if (rtimer_q[k] != '0) begin
              rtimer_d[k] = sat_sub(rtimer_q[k], tick_q);
            end else begin
              level_d[k] = '0;
            end
          end
        end
        OP_LINK_DOWN: begin
          link_d = 1'b0;
        end
        OP_SET_LEFT: begin
          level_d[0]  = item_i.amount;
          rtimer_d[0] = item_i.duration;
        end
        OP_SET_RIGHT: begin
          level_d[1]  = item_i.amount;
          rtimer_d[1] = item_i.duration;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      link_q      <= 1'b0;
      prev_q      <= '0;
      pressed_q   <= '0;
      released_q  <= '0;
      axis_q      <= '{default: '0};
      quad_q      <= QUAD_UR;
      gtimer_q    <= '0;
      level_q     <= '{default: '0};
      rtimer_q    <= '{default: '0};
    end else begin
      out_valid_q <= out_valid_d;
      link_q      <= link_d;
      prev_q      <= prev_d;
      pressed_q   <= pressed_d;
      released_q  <= released_d;
      axis_q      <= axis_d;
      quad_q      <= quad_d;
      gtimer_q    <= gtimer_d;
      level_q     <= level_d;
      rtimer_q    <= rtimer_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= AlphaReset;
      tick_q   <= TickReset;
      window_q <= WindowReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegAlpha:  alpha_q  <= cfg_wdata_i;
        RegTick:   tick_q   <= cfg_wdata_i[TickW-1:0];
        RegWindow: window_q <= cfg_wdata_i[TimeW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign link_up_o          = link_q;
  assign buttons_pressed_o  = ButtonW'(pressed_q);
  assign buttons_released_o = ButtonW'(released_q);
  assign left_x_smooth_o    = axis_q[AxisLeftX];
  assign left_y_smooth_o    = axis_q[AxisLeftY];
  assign right_x_smooth_o   = axis_q[AxisRightX];
  assign right_y_smooth_o   = axis_q[AxisRightY];
  assign rotation_done_o    = (quad_q == QUAD_UL);
  assign left_rumble_o      = level_q[0];
  assign right_rumble_o     = level_q[1];

  `GIC_ASSERT_NEXT(a_link_down_holds, pop_o && (item_i.op == OP_LINK_DOWN), !link_q && $stable(gtimer_q) && $stable(pressed_q), "link-down word changed state")
  `GIC_ASSERT_NEXT(a_result_held, out_valid_q && !out_ready_i, out_valid_q && $stable(quad_q) && $stable(gtimer_q) && $stable(prev_q), "waiting result changed")
  `GIC_ASSERT_NEXT(a_gesture_lapsed, pop_o && (item_i.op == OP_POLL) && !up_right && (gtimer_q == '0), quad_q == QUAD_UR, "gesture kept after window")

endmodule

>>> rtl/core/gamepad_input_conditioner_top.sv
// top level of the gamepad input conditioner
// One word is accepted per clock cycle while the queue is not full, and every word gives
// exactly one result word. The front end decodes the command into a two-entry queue, and
// the back end updates all state (button edges, four single-multiplier axis filters,
// gesture and rumble timers) in its registers, which sets the sustained rate of one word
// per cycle while the output is not stalled. The state registers double as the result
// register, so a stalled output only holds the back end while the queue keeps taking
// words until it is full. Configuration writes take effect at the next clock edge.
module gamepad_input_conditioner_top import gic_pkg::*; #(
  parameter int unsigned BUTTON_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CmdW-1:0]      cmd_i,
  input  logic                 connected_i,
  input  logic [ButtonW-1:0]   buttons_i,
  input  logic [AxisW-1:0]     left_stick_x_i,
  input  logic [AxisW-1:0]     left_stick_y_i,
  input  logic [AxisW-1:0]     right_stick_x_i,
  input  logic [AxisW-1:0]     right_stick_y_i,
  input  logic [LevelW-1:0]    rumble_amount_i,
  input  logic [TimeW-1:0]     rumble_time_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 link_up_o,
  output logic [ButtonW-1:0]   buttons_pressed_o,
  output logic [ButtonW-1:0]   buttons_released_o,
  output logic [AxisW-1:0]     left_x_smooth_o,
  output logic [AxisW-1:0]     left_y_smooth_o,
  output logic [AxisW-1:0]     right_x_smooth_o,
  output logic [AxisW-1:0]     right_y_smooth_o,
  output logic                 rotation_done_o,
  output logic [LevelW-1:0]    left_rumble_o,
  output logic [LevelW-1:0]    right_rumble_o
);

  gic_queue_status_t queue_status;
  gic_item_t         front_item;
  gic_item_t         queue_item;
  logic              push;
  logic              pop;

  gic_front #(
    .ButtonBits(BUTTON_BITS)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .connected_i     (connected_i),
    .buttons_i       (buttons_i),
    .left_stick_x_i  (left_stick_x_i),
    .left_stick_y_i  (left_stick_y_i),
    .right_stick_x_i (right_stick_x_i),
    .right_stick_y_i (right_stick_y_i),
    .rumble_amount_i (rumble_amount_i),
    .rumble_time_i   (rumble_time_i),
    .queue_status_i  (queue_status),
    .push_o          (push),
    .item_o          (front_item)
  );

  gic_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (queue_item),
    .status_o (queue_status)
  );

  gic_back #(
    .ButtonBits(BUTTON_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .item_valid_i       (queue_status.valid),
    .item_i             (queue_item),
    .pop_o              (pop),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .link_up_o          (link_up_o),
    .buttons_pressed_o  (buttons_pressed_o),
    .buttons_released_o (buttons_released_o),
    .left_x_smooth_o    (left_x_smooth_o),
    .left_y_smooth_o    (left_y_smooth_o),
    .right_x_smooth_o   (right_x_smooth_o),
    .right_y_smooth_o   (right_y_smooth_o),
    .rotation_done_o    (rotation_done_o),
    .left_rumble_o      (left_rumble_o),
    .right_rumble_o     (right_rumble_o)
  );

endmodule

>>> verif/gamepad_input_conditioner_top_tb.sv
// self-checking testbench of the gamepad input conditioner top level with a scoreboard class
module gamepad_input_conditioner_top_tb;
  import gic_pkg::*;

  localparam int ClkPeriod      = 8;
  localparam int ResetCycles    = 7;
  localparam int DrainCycles    = 16;
  localparam int TimeoutCycles  = 400000;
  localparam int SegmentWords   = 200;
  localparam int NumSegments    = 9;
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  typedef struct {
    logic [CmdW-1:0]         cmd;
    logic                    connected;
    logic [ButtonW-1:0]      buttons;
    logic signed [AxisW-1:0] lx;
    logic signed [AxisW-1:0] ly;
    logic signed [AxisW-1:0] rx;
    logic signed [AxisW-1:0] ry;
    logic [LevelW-1:0]       amount;
    logic [TimeW-1:0]        duration;
  } pad_word_t;

  typedef struct {
    logic                    link;
    logic [ButtonW-1:0]      pressed;
    logic [ButtonW-1:0]      released;
    logic signed [AxisW-1:0] lx;
    logic signed [AxisW-1:0] ly;
    logic signed [AxisW-1:0] rx;
    logic signed [AxisW-1:0] ry;
    logic                    rotation;
    logic [LevelW-1:0]       left_level;
    logic [LevelW-1:0]       right_level;
  } pad_report_t;

  class pad_scoreboard;
    logic [AlphaW-1:0]       alpha;
    logic [TickW-1:0]        tick;
    logic [TimeW-1:0]        window;
    logic [ButtonW-1:0]      held_buttons;
    logic [ButtonW-1:0]      pressed;
    logic [ButtonW-1:0]      released;
    logic signed [AxisW-1:0] axis_avg [NumAxes];
    gic_quad_e               quad;
    logic [TimeW-1:0]        gesture_left;
    logic [LevelW-1:0]       motor_level [2];
    logic [TimeW-1:0]        motor_time [2];
    logic                    link;
    pad_report_t             expected_reports [$];
    int                      errors;

    function new();
      alpha        = AlphaReset;
      tick         = TickReset;
      window       = WindowReset;
      held_buttons = '0;
      pressed      = '0;
      released     = '0;
      for (int i = 0; i < NumAxes; i++) axis_avg[i] = '0;
      quad         = QUAD_UR;
      gesture_left = '0;
      for (int k = 0; k < 2; k++) begin
        motor_level[k] = '0;
        motor_time[k]  = '0;
      end
      link         = 1'b0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegAlpha:  alpha  = data[AlphaW-1:0];
        RegTick:   tick   = data[TickW-1:0];
        RegWindow: window = data[TimeW-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [AxisW-1:0] smooth(logic signed [AxisW-1:0] s,
                                             logic signed [AxisW-1:0] x,
                                             logic [AlphaW-1:0] a);
      longint wa;
      longint acc;
      wa  = longint'(a);
      acc = (longint'(AlphaOne) - wa) * longint'(s) + wa * longint'(x) + 32768;
      return AxisW'(acc >>> FracBits);
    endfunction

    function void apply_poll(pad_word_t w);
      logic signed [AxisW-1:0] x [NumAxes];
      logic [AlphaW-1:0]       a;
      x[AxisLeftX]  = w.lx;
      x[AxisLeftY]  = w.ly;
      x[AxisRightX] = w.rx;
      x[AxisRightY] = w.ry;
      a = (alpha > AlphaOne) ? AlphaOne : alpha;
      pressed      = ~held_buttons & w.buttons;
      released     = held_buttons & ~w.buttons;
      held_buttons = w.buttons;
      for (int i = 0; i < NumAxes; i++) axis_avg[i] = smooth(axis_avg[i], x[i], a);
      if (x[AxisLeftX] > 0 && x[AxisLeftY] > 0) begin
        quad         = QUAD_UR;
        gesture_left = window;
      end
      if (gesture_left != 0) begin
        gesture_left = (gesture_left > tick) ? gesture_left - tick : '0;
        if (quad == QUAD_UL) quad = QUAD_UR;
        if (x[AxisLeftX] > 0 && x[AxisLeftY] <= 0 && quad == QUAD_UR) quad = QUAD_DR;
        if (x[AxisLeftX] <= 0 && x[AxisLeftY] < 0 && quad == QUAD_DR) quad = QUAD_DL;
        if (x[AxisLeftX] < 0 && x[AxisLeftY] >= 0 && quad == QUAD_DL) quad = QUAD_UL;
      end else begin
        quad = QUAD_UR;
      end
      for (int k = 0; k < 2; k++) begin
        if (motor_time[k] != 0) begin
          motor_time[k] = (motor_time[k] > tick) ? motor_time[k] - tick : '0;
        end else begin
          motor_level[k] = '0;
        end
      end
    endfunction

    function void note_word(pad_word_t w);
      pad_report_t r;
      case (w.cmd)
        CmdPoll: begin
          link = w.connected;
          if (w.connected) apply_poll(w);
        end
        CmdSetLeft: begin
          motor_level[0] = w.amount;
          motor_time[0]  = w.duration;
        end
        CmdSetRight: begin
          motor_level[1] = w.amount;
          motor_time[1]  = w.duration;
        end
        default: ;
      endcase
      r.link        = link;
      r.pressed     = pressed;
      r.released    = released;
      r.lx          = axis_avg[AxisLeftX];
      r.ly          = axis_avg[AxisLeftY];
      r.rx          = axis_avg[AxisRightX];
      r.ry          = axis_avg[AxisRightY];
      r.rotation    = (quad == QUAD_UL);
      r.left_level  = motor_level[0];
      r.right_level = motor_level[1];
      expected_reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] e, logic [15:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, e, a);
      end
    endfunction

    function void check_word(pad_report_t got);
      pad_report_t e;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, expected none actual %h",
                 $time, got.pressed);
        return;
      end
      e = expected_reports.pop_front();
      compare_field("link_up", 16'(e.link), 16'(got.link));
      compare_field("buttons_pressed", e.pressed, got.pressed);
      compare_field("buttons_released", e.released, got.released);
      compare_field("left_x_smooth", e.lx, got.lx);
      compare_field("left_y_smooth", e.ly, got.ly);
      compare_field("right_x_smooth", e.rx, got.rx);
      compare_field("right_y_smooth", e.ry, got.ry);
      compare_field("rotation_done", 16'(e.rotation), 16'(got.rotation));
      compare_field("left_rumble", e.left_level, got.left_level);
      compare_field("right_rumble", e.right_level, got.right_level);
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CmdW-1:0]     cmd_i;
  logic                connected_i;
  logic [ButtonW-1:0]  buttons_i;
  logic [AxisW-1:0]    left_stick_x_i;
  logic [AxisW-1:0]    left_stick_y_i;
  logic [AxisW-1:0]    right_stick_x_i;
  logic [AxisW-1:0]    right_stick_y_i;
  logic [LevelW-1:0]   rumble_amount_i;
  logic [TimeW-1:0]    rumble_time_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                link_up_o;
  logic [ButtonW-1:0]  buttons_pressed_o;
  logic [ButtonW-1:0]  buttons_released_o;
  logic [AxisW-1:0]    left_x_smooth_o;
  logic [AxisW-1:0]    left_y_smooth_o;
  logic [AxisW-1:0]    right_x_smooth_o;
  logic [AxisW-1:0]    right_y_smooth_o;
  logic                rotation_done_o;
  logic [LevelW-1:0]   left_rumble_o;
  logic [LevelW-1:0]   right_rumble_o;

  pad_scoreboard sb;
  pad_report_t   seen;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            long_hold_cycles;
  logic [ButtonW-1:0] last_buttons;
  gic_quad_e     sweep_quad;

  gamepad_input_conditioner_top u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .cmd_i              (cmd_i),
    .connected_i        (connected_i),
    .buttons_i          (buttons_i),
    .left_stick_x_i     (left_stick_x_i),
    .left_stick_y_i     (left_stick_y_i),
    .right_stick_x_i    (right_stick_x_i),
    .right_stick_y_i    (right_stick_y_i),
    .rumble_amount_i    (rumble_amount_i),
    .rumble_time_i      (rumble_time_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .link_up_o          (link_up_o),
    .buttons_pressed_o  (buttons_pressed_o),
    .buttons_released_o (buttons_released_o),
    .left_x_smooth_o    (left_x_smooth_o),
    .left_y_smooth_o    (left_y_smooth_o),
    .right_x_smooth_o   (right_x_smooth_o),
    .right_y_smooth_o   (right_y_smooth_o),
    .rotation_done_o    (rotation_done_o),
    .left_rumble_o      (left_rumble_o),
    .right_rumble_o     (right_rumble_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic pad_word_t make_poll(logic conn, logic [ButtonW-1:0] btn,
                                          logic [AxisW-1:0] lx, logic [AxisW-1:0] ly,
                                          logic [AxisW-1:0] rx, logic [AxisW-1:0] ry);
    pad_word_t w;
    w.cmd       = CmdPoll;
    w.connected = conn;
    w.buttons   = btn;
    w.lx        = lx;
    w.ly        = ly;
    w.rx        = rx;
    w.ry        = ry;
    w.amount    = LevelW'($urandom);
    w.duration  = TimeW'($urandom);
    return w;
  endfunction

  function automatic pad_word_t make_rumble(logic [CmdW-1:0] cmd, logic [LevelW-1:0] amount,
                                            logic [TimeW-1:0] duration);
    pad_word_t w;
    w          = make_poll(1'($urandom_range(1)), ButtonW'($urandom), AxisW'($urandom),
                           AxisW'($urandom), AxisW'($urandom), AxisW'($urandom));
    w.cmd      = cmd;
    w.amount   = amount;
    w.duration = duration;
    return w;
  endfunction

  function automatic logic signed [AxisW-1:0] signed_axis(int sgn, bit zero_ok);
    if (zero_ok && $urandom_range(7) == 0) return '0;
    if (sgn > 0) return ($urandom_range(15) == 0) ? 16'sh7FFF : 16'($urandom_range(1, 32767));
    return ($urandom_range(15) == 0) ? 16'sh8000 : 16'(-$urandom_range(1, 32767));
  endfunction

  function automatic logic signed [AxisW-1:0] random_axis();
    case ($urandom_range(15))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  // most words sweep the left stick through the gesture quadrants
  function automatic pad_word_t random_word();
    pad_word_t   w;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) w.cmd = CmdSetLeft;
    else if (r < 8) w.cmd = CmdSetRight;
    else if (r < 10) w.cmd = CmdUnused;
    else w.cmd = CmdPoll;
    w.connected = ($urandom_range(99) >= 8);
    if ($urandom_range(1)) w.buttons = last_buttons ^ (16'h1 << $urandom_range(15));
    else w.buttons = ButtonW'($urandom);
    last_buttons = w.buttons;
    if ($urandom_range(9) < 7) begin
      case (sweep_quad)
        QUAD_UR: begin
          w.lx = signed_axis(1, 1'b0);
          w.ly = signed_axis(1, 1'b0);
        end
        QUAD_DR: begin
          w.lx = signed_axis(1, 1'b0);
          w.ly = signed_axis(-1, 1'b1);
        end
        QUAD_DL: begin
          w.lx = signed_axis(-1, 1'b1);
          w.ly = signed_axis(-1, 1'b0);
        end
        default: begin
          w.lx = signed_axis(-1, 1'b0);
          w.ly = signed_axis(1, 1'b1);
        end
      endcase
      r = $urandom_range(19);
      if (r == 0) sweep_quad = QUAD_UR;
      else if (r < 17) sweep_quad = (sweep_quad == QUAD_UL) ? QUAD_UR :
                                    gic_quad_e'(sweep_quad + 2'd1);
    end else begin
      w.lx = random_axis();
      w.ly = random_axis();
    end
    w.rx       = random_axis();
    w.ry       = random_axis();
    w.amount   = LevelW'($urandom);
    w.duration = ($urandom_range(9) < 7) ? 16'($urandom_range(300)) : 16'($urandom);
    return w;
  endfunction

  task automatic send_word(input pad_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= w.cmd;
    connected_i     <= w.connected;
    buttons_i       <= w.buttons;
    left_stick_x_i  <= w.lx;
    left_stick_y_i  <= w.ly;
    right_stick_x_i <= w.rx;
    right_stick_y_i <= w.ry;
    rumble_amount_i <= w.amount;
    rumble_time_i   <= w.duration;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
    @(negedge clk_i);
  endtask

  task automatic wait_for_reports();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic set_config(input logic [AlphaW-1:0] alpha, input logic [TickW-1:0] tick,
                            input logic [TimeW-1:0] window);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegAlpha;
    cfg_wdata_i <= CfgDataW'(alpha);
    sb.write_reg(RegAlpha, CfgDataW'(alpha));
    @(negedge clk_i);
    cfg_idx_i   <= RegTick;
    cfg_wdata_i <= CfgDataW'(tick);
    sb.write_reg(RegTick, CfgDataW'(tick));
    @(negedge clk_i);
    cfg_idx_i   <= RegWindow;
    cfg_wdata_i <= CfgDataW'(window);
    sb.write_reg(RegWindow, CfgDataW'(window));
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        long_hold_cycles--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.link        = link_up_o;
      seen.pressed     = buttons_pressed_o;
      seen.released    = buttons_released_o;
      seen.lx          = left_x_smooth_o;
      seen.ly          = left_y_smooth_o;
      seen.rx          = right_x_smooth_o;
      seen.ry          = right_y_smooth_o;
      seen.rotation    = rotation_done_o;
      seen.left_level  = left_rumble_o;
      seen.right_level = right_rumble_o;
      sb.check_word(seen);
    end
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sb               = new();
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    long_hold_cycles = 0;
    last_buttons     = '0;
    sweep_quad       = QUAD_UR;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = RegAlpha;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    cmd_i            = CmdPoll;
    connected_i      = 1'b0;
    buttons_i        = '0;
    left_stick_x_i   = '0;
    left_stick_y_i   = '0;
    right_stick_x_i  = '0;
    right_stick_y_i  = '0;
    rumble_amount_i  = '0;
    rumble_time_i    = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // full gesture sweep with the reset settings
    send_word(make_poll(1'b1, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF));
    send_word(make_poll(1'b1, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h8000));
    send_word(make_poll(1'b1, 16'hA5A5, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001));
    send_word(make_poll(1'b1, 16'h5A5A, 16'h8000, 16'h0000, 16'hFFFF, 16'h8000));
    send_word(make_poll(1'b1, 16'h5A5A, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF));
    // link down holds everything
    send_word(make_poll(1'b0, 16'h1234, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_word(make_rumble(CmdSetLeft, 16'hFFFF, 16'd20));
    send_word(make_rumble(CmdSetRight, 16'h0001, 16'hFFFF));
    send_word(make_rumble(CmdUnused, LevelW'($urandom), TimeW'($urandom)));
    // left timer runs down, saturates and then drops the level
    send_word(make_poll(1'b1, 16'h0001, 16'h0100, 16'h0100, 16'h0000, 16'h0000));
    send_word(make_poll(1'b1, 16'h8000, 16'h0100, 16'h8000, 16'h0000, 16'h0000));
    send_word(make_poll(1'b1, 16'h8000, 16'h8000, 16'h0100, 16'h0000, 16'h0000));
    wait_for_reports();
    // unity weight, frozen timers, empty gesture window
    set_config(AlphaOne, '0, '0);
    send_word(make_poll(1'b1, 16'h00FF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h1234));
    send_word(make_poll(1'b1, 16'hFF00, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
    wait_for_reports();
    // weight above one, largest tick, largest window
    set_config(17'h1FFFF, 10'h3FF, 16'hFFFF);
    send_word(make_poll(1'b1, 16'hFFFF, 16'h4000, 16'h4000, 16'hC000, 16'h0001));
    send_word(make_poll(1'b1, 16'h0000, 16'h4000, 16'hC000, 16'h8000, 16'h7FFF));
    wait_for_reports();
    // zero weight freezes the filters
    set_config('0, 10'd1000, 16'd1);
    send_word(make_poll(1'b1, 16'h0F0F, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_word(make_poll(1'b1, 16'hF0F0, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000));
    send_word(make_rumble(CmdSetLeft, 16'h8000, 16'd999));
    send_word(make_poll(1'b1, 16'hF0F0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_word(make_poll(1'b1, 16'hF0F0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

    for (int seg = 0; seg < NumSegments; seg++) begin
      wait_for_reports();
      case (seg)
        1:       set_config(AlphaOne, 10'd1, 16'hFFFF);
        3:       set_config('0, 10'd1000, '0);
        4:       set_config(17'h1FFFF, '0, 16'd600);
        6:       set_config(17'd1, 10'h3FF, 16'hFFFF);
        default: set_config(AlphaW'($urandom_range(0, 65536)), TickW'($urandom_range(1, 64)),
                            TimeW'($urandom_range(100, 4000)));
      endcase
      if (seg < 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 86;
      end else if (seg < 6) begin
        send_idle_pct = 86;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long output stall while words keep coming
      if (seg == 7) long_hold_cycles = 150;
      repeat (SegmentWords) send_word(random_word());
    end

    wait_for_reports();
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/gic_pkg.sv
rtl/core/gic_front.sv
rtl/core/gic_queue.sv
rtl/core/gic_back.sv
rtl/core/gamepad_input_conditioner_top.sv
verif/gamepad_input_conditioner_top_tb.sv
